// File: rtl/core/functional_chi_square_stat_unit_assert.svh
// assertion macros for the chi-square unit
`ifndef FUNCTIONAL_CHI_SQUARE_STAT_UNIT_ASSERT_SVH
`define FUNCTIONAL_CHI_SQUARE_STAT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FCS_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FCS_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg
// shared types and constants of the chi-square statistic unit
// ----------------------------------------------------------------------------
package fcs_pkg;
  localparam int unsigned STAT_BITS = 44;
  localparam int unsigned CFG_BITS  = 5;
  localparam int unsigned ADDR_BITS = 3;
  localparam logic [ADDR_BITS-1:0] REG_ROWS = 3'd0;
  localparam logic [ADDR_BITS-1:0] REG_COLS = 3'd4;

  typedef enum logic [2:0] {
    BK_IDLE, BK_ROWDIV, BK_COLSQ, BK_COLDIV, BK_FINAL, BK_MUL, BK_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE, DIV_RUN, DIV_DONE
  } div_state_e;
endpackage

// File: rtl/core/fcs_if.sv
// ----------------------------------------------------------------------------
// fcs_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface fcs_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/functional_chi_square_stat_unit.sv
// Functional chi-square unit: cells of a rows_in_use x cols_in_use table stream in
// row-major order, one per handshake; one result item follows the last cell. Each
// division in the shared bit-serial divider produces NW quotient bits, where NW =
// FRAC_BITS+2*(COUNT_BITS+log2(MAX_ROWS)+log2(MAX_COLS)) (64 by default); the back
// part runs one division for each nonzero row and one for each column of the walk
// after the last row, then clamps, scales and loads the result. The last cell of a row
// stalls while the previous row still waits in the queue register, and the last cell of
// a table stalls until the previous table's result has been loaded into the output
// register, so sustained throughput per cell is set by that divider work spread over
// the row's cells.
// ----------------------------------------------------------------------------
// functional_chi_square_stat_unit
// top level: config registers, cell front part, divider back part
// ----------------------------------------------------------------------------
`include "functional_chi_square_stat_unit_assert.svh"
module functional_chi_square_stat_unit #(
  parameter int unsigned MAX_ROWS   = 16,
  parameter int unsigned MAX_COLS   = 16,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [fcs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  fcs_if.sink         cell_in,
  fcs_if.source       res_out
);
  localparam int unsigned RI_BITS = $clog2(MAX_ROWS);
  localparam int unsigned CI_BITS = $clog2(MAX_COLS);
  localparam int unsigned SZ_BITS = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
  localparam int unsigned RT_BITS = COUNT_BITS + CI_BITS;
  localparam int unsigned RS_BITS = 2 * COUNT_BITS + CI_BITS;
  localparam int unsigned GT_BITS = COUNT_BITS + RI_BITS + CI_BITS;
  localparam int unsigned ACC_BITS = 2 * GT_BITS + FRAC_BITS;

  logic [fcs_pkg::CFG_BITS-1:0] rows_q, cols_q;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 5'd16;
      cols_q <= 5'd16;
    end else if (wr) begin
      unique case (paddr)
        fcs_pkg::REG_ROWS: rows_q <= pwdata[4:0];
        fcs_pkg::REG_COLS: cols_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr)
      fcs_pkg::REG_ROWS: prdata = 32'(rows_q);
      fcs_pkg::REG_COLS: prdata = 32'(cols_q);
      default:           prdata = '0;
    endcase
  end

  logic               job_valid, job_ready, job_last, tbl_free;
  logic [RT_BITS-1:0] job_rt;
  logic [RS_BITS-1:0] job_rs;
  logic [GT_BITS-1:0] job_gt, col_data;
  logic [SZ_BITS-1:0] job_cols;
  logic [CI_BITS-1:0] col_idx;

  fcs_front #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .COUNT_BITS(COUNT_BITS),
    .RT_BITS(RT_BITS), .RS_BITS(RS_BITS), .GT_BITS(GT_BITS),
    .RI_BITS(RI_BITS), .CI_BITS(CI_BITS), .SZ_BITS(SZ_BITS)
  ) u_front (
    .clk_i, .rst_ni, .rows_cfg_i(rows_q), .cols_cfg_i(cols_q), .cell_in,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_rt_o(job_rt),
    .job_rs_o(job_rs), .job_last_o(job_last), .job_gt_o(job_gt),
    .job_cols_o(job_cols), .tbl_free_i(tbl_free), .col_rd_i(col_idx),
    .col_rd_o(col_data)
  );

  fcs_back #(
    .MAX_COLS(MAX_COLS), .FRAC_BITS(FRAC_BITS), .RT_BITS(RT_BITS),
    .RS_BITS(RS_BITS), .GT_BITS(GT_BITS), .CI_BITS(CI_BITS),
    .SZ_BITS(SZ_BITS), .ACC_BITS(ACC_BITS)
  ) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_rt_i(job_rt), .job_rs_i(job_rs), .job_last_i(job_last),
    .job_gt_i(job_gt), .job_cols_i(job_cols), .tbl_free_o(tbl_free),
    .col_rd_o(col_idx), .col_rd_i(col_data), .res_out
  );

  // a result that is shown never changes until taken
  `FCS_ASSERT(a_res_hold, clk_i, rst_ni,
    res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.data),
    "result changed while stalled")
  // an empty table always reports a zero statistic
  `FCS_ASSERT(a_empty_zero, clk_i, rst_ni,
    res_out.valid && res_out.data[0] |-> res_out.data[fcs_pkg::STAT_BITS:1] == '0,
    "empty table with nonzero statistic")
endmodule

// File: rtl/core/fcs_div.sv
// ----------------------------------------------------------------------------
// fcs_div
// restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module fcs_div #(
  parameter int unsigned NW = 56,
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  fcs_pkg::div_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quot_q, quot_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW+1:0] trial;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    den_d   = den_q;
    trial   = {rem_q, quot_q[NW-1]} - {2'b00, den_q};
    unique case (state_q)
      fcs_pkg::DIV_IDLE: begin
        if (start_i) begin
          quot_d  = num_i;
          rem_d   = '0;
          den_d   = den_i;
          cnt_d   = CW'(NW);
          state_d = fcs_pkg::DIV_RUN;
        end
      end
      fcs_pkg::DIV_RUN: begin
        if (!trial[DW+1]) begin
          rem_d  = trial[DW:0];
          quot_d = {quot_q[NW-2:0], 1'b1};
        end else begin
          rem_d  = {rem_q[DW-1:0], quot_q[NW-1]};
          quot_d = {quot_q[NW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) state_d = fcs_pkg::DIV_DONE;
      end
      fcs_pkg::DIV_DONE: state_d = fcs_pkg::DIV_IDLE;
      default: state_d = fcs_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcs_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = (state_q == fcs_pkg::DIV_DONE);
  assign quot_o = quot_q;
endmodule

// File: rtl/core/fcs_front.sv
// ----------------------------------------------------------------------------
// fcs_front
// accepts cells, keeps row and column sums, queues finished rows and tables
// ----------------------------------------------------------------------------
module fcs_front #(
  parameter int unsigned MAX_ROWS   = 16,
  parameter int unsigned MAX_COLS   = 16,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned RT_BITS    = 20,
  parameter int unsigned RS_BITS    = 36,
  parameter int unsigned GT_BITS    = 24,
  parameter int unsigned RI_BITS    = 4,
  parameter int unsigned CI_BITS    = 4,
  parameter int unsigned SZ_BITS    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          rows_cfg_i,
  input  logic [4:0]          cols_cfg_i,
  fcs_if.sink                 cell_in,
  // row job queue entry
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output logic [RT_BITS-1:0]  job_rt_o,
  output logic [RS_BITS-1:0]  job_rs_o,
  output logic                job_last_o,
  output logic [GT_BITS-1:0]  job_gt_o,
  output logic [SZ_BITS-1:0]  job_cols_o,
  // column totals of the table in the back part
  input  logic                tbl_free_i,
  input  logic [CI_BITS-1:0]  col_rd_i,
  output logic [GT_BITS-1:0]  col_rd_o
);
  logic [GT_BITS-1:0] col_q [MAX_COLS];
  logic [GT_BITS-1:0] colb_q [MAX_COLS];
  logic [RT_BITS-1:0] rt_q;
  logic [RS_BITS-1:0] rs_q;
  logic [GT_BITS-1:0] gt_q;
  logic [RI_BITS-1:0] rp_q;
  logic [CI_BITS-1:0] cp_q;
  logic [SZ_BITS-1:0] ar_q, ac_q, ar_c, ac_c, r_sz, c_sz;
  logic               first, row_end, tbl_end, acc, stall;
  logic [RT_BITS-1:0] rt_n;
  logic [RS_BITS-1:0] rs_n;
  logic [GT_BITS-1:0] gt_n;
  logic [COUNT_BITS-1:0] cnt_in;
  // one-entry output register
  logic               ov_q;
  logic [RT_BITS-1:0] ort_q;
  logic [RS_BITS-1:0] ors_q;
  logic               olast_q;
  logic [GT_BITS-1:0] ogt_q;
  logic [SZ_BITS-1:0] oc_q;
  // a finished table waits until the back part releases its column copy
  logic               tbusy_q;

  assign cnt_in = cell_in.data;
  assign first = (rp_q == '0) && (cp_q == '0);
  assign r_sz  = (rows_cfg_i == '0) ? SZ_BITS'(1) :
                 (32'(rows_cfg_i) > MAX_ROWS) ? SZ_BITS'(MAX_ROWS) : SZ_BITS'(rows_cfg_i);
  assign c_sz  = (cols_cfg_i == '0) ? SZ_BITS'(1) :
                 (32'(cols_cfg_i) > MAX_COLS) ? SZ_BITS'(MAX_COLS) : SZ_BITS'(cols_cfg_i);
  assign ar_c  = first ? r_sz : ar_q;
  assign ac_c  = first ? c_sz : ac_q;
  assign row_end = (SZ_BITS'(cp_q) + 1'b1) >= ac_c;
  assign tbl_end = row_end && ((SZ_BITS'(rp_q) + 1'b1) >= ar_c);
  assign stall = row_end && (ov_q && !job_ready_i || tbl_end && tbusy_q);
  assign cell_in.ready = !stall;
  assign acc = cell_in.valid && !stall;

  assign rt_n = (first ? '0 : rt_q) + RT_BITS'(cnt_in);
  assign rs_n = (first ? '0 : rs_q) + RS_BITS'(cnt_in) * RS_BITS'(cnt_in);
  assign gt_n = (first ? '0 : gt_q) + GT_BITS'(cnt_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
      cp_q <= '0;
      ar_q <= SZ_BITS'(MAX_ROWS);
      ac_q <= SZ_BITS'(MAX_COLS);
      ov_q <= 1'b0;
      tbusy_q <= 1'b0;
    end else begin
      if (acc && row_end) ov_q <= 1'b1;
      else if (job_valid_o && job_ready_i) ov_q <= 1'b0;
      if (acc && tbl_end) tbusy_q <= 1'b1;
      else if (tbl_free_i) tbusy_q <= 1'b0;
      if (acc) begin
        ar_q <= ar_c;
        ac_q <= ac_c;
        if (row_end) begin
          cp_q <= '0;
          if (tbl_end) begin
            rp_q <= '0;
          end else begin
            rp_q <= rp_q + 1'b1;
          end
        end else begin
          cp_q <= cp_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rt_q <= row_end ? '0 : rt_n;
      rs_q <= row_end ? '0 : rs_n;
      gt_q <= gt_n;
      for (int j = 0; j < MAX_COLS; j++) begin
        if (first && CI_BITS'(j) != cp_q) col_q[j] <= '0;
        else if (CI_BITS'(j) == cp_q) col_q[j] <= (first ? '0 : col_q[j]) + GT_BITS'(cnt_in);
      end
      if (tbl_end) begin
        for (int j = 0; j < MAX_COLS; j++) begin
          colb_q[j] <= (first ? '0 : col_q[j]) +
                       ((CI_BITS'(j) == cp_q) ? GT_BITS'(cnt_in) : '0);
        end
      end
      if (row_end) begin
        ort_q   <= rt_n;
        ors_q   <= rs_n;
        olast_q <= tbl_end;
        ogt_q   <= gt_n;
        oc_q    <= ac_c;
      end
    end
  end

  assign job_valid_o = ov_q;
  assign job_rt_o    = ort_q;
  assign job_rs_o    = ors_q;
  assign job_last_o  = olast_q;
  assign job_gt_o    = ogt_q;
  assign job_cols_o  = oc_q;
  assign col_rd_o    = colb_q[col_rd_i];
endmodule

// File: rtl/core/fcs_back.sv
// ----------------------------------------------------------------------------
// fcs_back
// row quotients, column walk, clamp, scale and result register
// ----------------------------------------------------------------------------
module fcs_back #(
  parameter int unsigned MAX_COLS  = 16,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned RT_BITS   = 20,
  parameter int unsigned RS_BITS   = 36,
  parameter int unsigned GT_BITS   = 24,
  parameter int unsigned CI_BITS   = 4,
  parameter int unsigned SZ_BITS   = 5,
  parameter int unsigned ACC_BITS  = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  logic [RT_BITS-1:0]  job_rt_i,
  input  logic [RS_BITS-1:0]  job_rs_i,
  input  logic                job_last_i,
  input  logic [GT_BITS-1:0]  job_gt_i,
  input  logic [SZ_BITS-1:0]  job_cols_i,
  output logic                tbl_free_o,
  output logic [CI_BITS-1:0]  col_rd_o,
  input  logic [GT_BITS-1:0]  col_rd_i,
  fcs_if.source               res_out
);
  localparam int unsigned SQ_BITS = 2 * GT_BITS;
  localparam int unsigned NW = SQ_BITS + FRAC_BITS;
  localparam int unsigned SB = fcs_pkg::STAT_BITS;
  localparam logic [SB-1:0] STAT_MAX = '1;

  fcs_pkg::back_state_e st_q, st_d;
  logic [ACC_BITS-1:0] racc_q, racc_d, cacc_q, cacc_d, diff_q, diff_d;
  logic [CI_BITS-1:0]  ci_q, ci_d;
  logic [SQ_BITS-1:0]  sq_q, sq_d;
  logic [GT_BITS-1:0]  gt_q, gt_d;
  logic [SZ_BITS-1:0]  nc_q, nc_d;
  logic                last_q, last_d;
  logic                ov_q, ov_d, tf;
  logic [SB-1:0]       stat_q, stat_d;
  logic                emp_q, emp_d;
  logic                dstart;
  logic [NW-1:0]       dnum, dq;
  logic [GT_BITS-1:0]  dden;
  logic                ddone;
  logic [ACC_BITS+SZ_BITS-1:0] prod;

  fcs_div #(.NW(NW), .DW(GT_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quot_o(dq)
  );

  assign col_rd_o = ci_q;
  assign prod = ACC_BITS'(diff_q) * (ACC_BITS+SZ_BITS)'(nc_q);

  always_comb begin
    st_d = st_q; racc_d = racc_q; cacc_d = cacc_q; diff_d = diff_q;
    ci_d = ci_q; sq_d = sq_q; gt_d = gt_q; nc_d = nc_q; last_d = last_q;
    ov_d = ov_q; stat_d = stat_q; emp_d = emp_q;
    dstart = 1'b0; dnum = '0; dden = gt_q; tf = 1'b0;
    job_ready_o = 1'b0;
    if (res_out.ready) ov_d = 1'b0;
    unique case (st_q)
      fcs_pkg::BK_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          gt_d = job_gt_i; nc_d = job_cols_i; last_d = job_last_i;
          if (job_rt_i != '0) begin
            dstart = 1'b1;
            dnum = NW'({job_rs_i, FRAC_BITS'(0)});
            dden = GT_BITS'(job_rt_i);
            st_d = fcs_pkg::BK_ROWDIV;
          end else if (job_last_i) begin
            st_d = fcs_pkg::BK_FINAL;
          end
        end
      end
      fcs_pkg::BK_ROWDIV: begin
        dden = gt_q;
        if (ddone) begin
          racc_d = racc_q + ACC_BITS'(dq);
          st_d = last_q ? fcs_pkg::BK_FINAL : fcs_pkg::BK_IDLE;
        end
      end
      fcs_pkg::BK_FINAL: begin
        ci_d = '0; cacc_d = '0;
        if (gt_q == '0) begin
          st_d = fcs_pkg::BK_OUT;
        end else begin
          st_d = fcs_pkg::BK_COLSQ;
        end
      end
      fcs_pkg::BK_COLSQ: begin
        sq_d = SQ_BITS'(col_rd_i) * SQ_BITS'(col_rd_i);
        st_d = fcs_pkg::BK_COLDIV;
        dstart = 1'b0;
      end
      fcs_pkg::BK_COLDIV: begin
        if (!ddone) begin
          dstart = 1'b1;
          dnum = NW'({sq_q, FRAC_BITS'(0)});
        end else begin
          cacc_d = cacc_q + ACC_BITS'(dq);
          if ((SZ_BITS'(ci_q) + 1'b1) >= nc_q) begin
            st_d = fcs_pkg::BK_MUL;
          end else begin
            ci_d = ci_q + 1'b1;
            st_d = fcs_pkg::BK_COLSQ;
          end
        end
      end
      fcs_pkg::BK_MUL: begin
        diff_d = (racc_q > cacc_q) ? racc_q - cacc_q : '0;
        st_d = fcs_pkg::BK_OUT;
      end
      fcs_pkg::BK_OUT: begin
        // result register loads only once the previous item has gone
        if (!ov_q || res_out.ready) begin
          ov_d = 1'b1; racc_d = '0; tf = 1'b1;
          emp_d = (gt_q == '0);
          stat_d = (gt_q == '0) ? '0 :
                   (prod > (ACC_BITS+SZ_BITS)'(STAT_MAX)) ? STAT_MAX : SB'(prod);
          st_d = fcs_pkg::BK_IDLE;
        end
      end
      default: st_d = fcs_pkg::BK_IDLE;
    endcase
  end

  assign tbl_free_o = tf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= fcs_pkg::BK_IDLE;
      ov_q <= 1'b0;
      racc_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      racc_q <= racc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cacc_q <= cacc_d; diff_q <= diff_d; ci_q <= ci_d; sq_q <= sq_d;
    gt_q <= gt_d; nc_q <= nc_d; last_q <= last_d;
    stat_q <= stat_d; emp_q <= emp_d;
  end

  assign res_out.valid = ov_q;
  assign res_out.data  = {stat_q, emp_q};
endmodule
